// File: sv/hsv_pkg.sv
// package: widths, constants, word types and hue sector codes for the hsv to rgb converter
package hsv_pkg;

    localparam int HueW  = 16;
    localparam int PctW  = 7;
    localparam int ChanW = 8;
    localparam int QuotW = 11;   // hue / 60 for any 16-bit hue
    localparam int OffW  = 6;    // offset within a sector, 0..59

    localparam logic [PctW-1:0] PCT_FULL   = 7'd100;
    localparam logic [15:0]     HUE_SECTOR = 16'd60;
    localparam logic [10:0]     SECTOR_CNT = 11'd6;

    // reciprocal multipliers, exact over the value ranges that reach them
    localparam logic [16:0] DIV60_MUL    = 17'd69906;    // hue / 60
    localparam int          DIV60_SHIFT  = 22;
    localparam logic [9:0]  DIV6_MUL     = 10'd683;      // quotient / 6
    localparam int          DIV6_SHIFT   = 12;
    localparam logic [20:0] HI_MUL       = 21'd1336965;  // v * 255 / 100
    localparam int          HI_SHIFT     = 19;
    localparam logic [12:0] DIV100_MUL   = 13'd5243;     // x / 100
    localparam int          DIV100_SHIFT = 19;
    localparam logic [14:0] ADJ_MUL      = 15'd17477;    // x / 60
    localparam int          ADJ_SHIFT    = 20;

    typedef enum logic [2:0] {
        SEC_RED_GREEN_UP    = 3'd0,
        SEC_GREEN_RED_DOWN  = 3'd1,
        SEC_GREEN_BLUE_UP   = 3'd2,
        SEC_BLUE_GREEN_DOWN = 3'd3,
        SEC_BLUE_RED_UP     = 3'd4,
        SEC_RED_BLUE_DOWN   = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HueW-1:0] hue;
        logic [PctW-1:0] saturation;
        logic [PctW-1:0] brightness;
    } hsv_word_t;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } rgb_word_t;

    // between split and scale
    typedef struct packed {
        logic [OffW-1:0]  offset;
        sector_t          sector;
        logic [ChanW-1:0] hi;
        logic [PctW-1:0]  sat;
    } level_word_t;

    // between scale and mix
    typedef struct packed {
        logic [OffW-1:0]  offset;
        sector_t          sector;
        logic [ChanW-1:0] hi;
        logic [ChanW-1:0] lo;
    } mix_word_t;

endpackage

// File: sv/hsv_to_rgb_converter.sv
// top level: pipelined hsv to rgb pixel converter
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+------------------------------------------
//  hsv     | in  | hsv_valid / hsv_ready | hue[15:0], saturation[6:0], brightness[6:0]
//  rgb     | out | rgb_valid / rgb_ready | red[7:0], green[7:0], blue[7:0]
//
// seven register stages, one word in and one word out per clock when rgb_ready stays high
// the hsv word accepted at stage 1 moves through stages 2 to 6 in turn before stage 7 loads its rgb word
// each stage holds its own valid bit and loads whenever it is empty or its successor
// moves, so bubbles are squeezed out and a stalled word is held in place, never dropped
// rst_n clears all valid bits asynchronously; data registers carry no reset
module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hsv_valid,
    output logic      hsv_ready,
    input  hsv_word_t hsv,
    output logic      rgb_valid,
    input  logic      rgb_ready,
    output rgb_word_t rgb
);

    // split -> scale
    logic        lvl_valid;
    logic        lvl_ready;
    level_word_t lvl_word;

    // scale -> mix
    logic        mix_valid;
    logic        mix_ready;
    mix_word_t   mix_word;

    // stages 1-2: hue / 60 and its sector mod 6, clamp of s and v, hi = v * 255 / 100
    hsv_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (hsv_valid),
        .src_ready (hsv_ready),
        .src_word  (hsv),
        .dst_valid (lvl_valid),
        .dst_ready (lvl_ready),
        .dst_word  (lvl_word)
    );

    // stages 3-4: lo = hi * (100 - s) / 100
    hsv_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (lvl_valid),
        .src_ready (lvl_ready),
        .src_word  (lvl_word),
        .dst_valid (mix_valid),
        .dst_ready (mix_ready),
        .dst_word  (mix_word)
    );

    // stages 5-7: adjust = (hi - lo) * offset / 60, per-sector channel pick, output word
    hsv_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (mix_valid),
        .src_ready (mix_ready),
        .src_word  (mix_word),
        .dst_valid (rgb_valid),
        .dst_ready (rgb_ready),
        .dst_word  (rgb)
    );

endmodule

// File: sv/hsv_split.sv
// stages 1-2: hue sector and offset, percent clamps, channel maximum
module hsv_split
    import hsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_ready,
    input  hsv_word_t   src_word,
    output logic        dst_valid,
    input  logic        dst_ready,
    output level_word_t dst_word
);

    logic              s1_valid_reg;
    logic [HueW-1:0]   s1_hue_reg;
    logic [QuotW-1:0]  s1_q60_reg;
    logic [PctW-1:0]   s1_sat_reg;
    logic [PctW-1:0]   s1_val_reg;
    logic              s2_valid_reg;
    level_word_t       s2_word_reg;

    logic              s1_ready;
    logic              s2_ready;
    logic [32:0]       hue_prod;
    logic [QuotW-1:0]  q60_next;
    logic [PctW-1:0]   sat_next;
    logic [PctW-1:0]   val_next;
    logic [15:0]       hue_base;
    logic [15:0]       off_diff;
    logic [20:0]       q6_prod;
    logic [7:0]        q6;
    logic [10:0]       sec_diff;
    logic [27:0]       hi_prod;
    level_word_t       s2_next;

    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s2_ready  = !s2_valid_reg || dst_ready;
    assign src_ready = s1_ready;
    assign dst_valid = s2_valid_reg;
    assign dst_word  = s2_word_reg;

    // stage 1: hue / 60 by reciprocal, clamp percents
    always_comb
    begin
        hue_prod = 33'(src_word.hue) * 33'(DIV60_MUL);
        q60_next = hue_prod[DIV60_SHIFT +: QuotW];
        sat_next = (src_word.saturation > PCT_FULL) ? PCT_FULL : src_word.saturation;
        val_next = (src_word.brightness > PCT_FULL) ? PCT_FULL : src_word.brightness;
    end

    // stage 2: offset, sector = (hue / 60) mod 6, hi = v * 255 / 100
    always_comb
    begin
        hue_base = 16'(s1_q60_reg) * HUE_SECTOR;
        off_diff = s1_hue_reg - hue_base;
        q6_prod  = 21'(s1_q60_reg) * 21'(DIV6_MUL);
        q6       = q6_prod[DIV6_SHIFT +: 8];
        sec_diff = s1_q60_reg - 11'(11'(q6) * SECTOR_CNT);
        hi_prod  = 28'(s1_val_reg) * 28'(HI_MUL);
        s2_next.offset = off_diff[OffW-1:0];
        s2_next.sector = sector_t'(sec_diff[2:0]);
        s2_next.hi     = hi_prod[HI_SHIFT +: ChanW];
        s2_next.sat    = s1_sat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= src_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && src_valid)
        begin
            s1_hue_reg <= src_word.hue;
            s1_q60_reg <= q60_next;
            s1_sat_reg <= sat_next;
            s1_val_reg <= val_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_word_reg <= s2_next;
        end
    end

endmodule

// File: sv/hsv_scale.sv
// stages 3-4: channel minimum from maximum and saturation
module hsv_scale
    import hsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_ready,
    input  level_word_t src_word,
    output logic        dst_valid,
    input  logic        dst_ready,
    output mix_word_t   dst_word
);

    logic              s3_valid_reg;
    logic [14:0]       s3_lo_num_reg;
    logic [OffW-1:0]   s3_offset_reg;
    sector_t           s3_sector_reg;
    logic [ChanW-1:0]  s3_hi_reg;
    logic              s4_valid_reg;
    mix_word_t         s4_word_reg;

    logic              s3_ready;
    logic              s4_ready;
    logic [14:0]       lo_num_next;
    logic [27:0]       lo_prod;
    mix_word_t         s4_next;

    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s4_ready  = !s4_valid_reg || dst_ready;
    assign src_ready = s3_ready;
    assign dst_valid = s4_valid_reg;
    assign dst_word  = s4_word_reg;

    // hi * (100 - s), then / 100 by reciprocal
    assign lo_num_next = 15'(src_word.hi) * 15'(PCT_FULL - src_word.sat);

    always_comb
    begin
        lo_prod        = 28'(s3_lo_num_reg) * 28'(DIV100_MUL);
        s4_next.offset = s3_offset_reg;
        s4_next.sector = s3_sector_reg;
        s4_next.hi     = s3_hi_reg;
        s4_next.lo     = lo_prod[DIV100_SHIFT +: ChanW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= src_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && src_valid)
        begin
            s3_lo_num_reg <= lo_num_next;
            s3_offset_reg <= src_word.offset;
            s3_sector_reg <= src_word.sector;
            s3_hi_reg     <= src_word.hi;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_word_reg <= s4_next;
        end
    end

endmodule

// File: sv/hsv_mix.sv
// stages 5-7: ramp adjust within the sector and channel select into the output register
module hsv_mix
    import hsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  mix_word_t src_word,
    output logic      dst_valid,
    input  logic      dst_ready,
    output rgb_word_t dst_word
);

    logic              s5_valid_reg;
    logic [13:0]       s5_adj_num_reg;
    sector_t           s5_sector_reg;
    logic [ChanW-1:0]  s5_hi_reg;
    logic [ChanW-1:0]  s5_lo_reg;
    logic              s6_valid_reg;
    logic [ChanW-1:0]  s6_adj_reg;
    sector_t           s6_sector_reg;
    logic [ChanW-1:0]  s6_hi_reg;
    logic [ChanW-1:0]  s6_lo_reg;
    logic              s7_valid_reg;
    rgb_word_t         s7_word_reg;

    logic              s5_ready;
    logic              s6_ready;
    logic              s7_ready;
    logic [13:0]       adj_num_next;
    logic [28:0]       adj_prod;
    logic [ChanW-1:0]  adj_next;
    logic [ChanW-1:0]  up;
    logic [ChanW-1:0]  down;
    rgb_word_t         s7_next;

    assign s5_ready  = !s5_valid_reg || s6_ready;
    assign s6_ready  = !s6_valid_reg || s7_ready;
    assign s7_ready  = !s7_valid_reg || dst_ready;
    assign src_ready = s5_ready;
    assign dst_valid = s7_valid_reg;
    assign dst_word  = s7_word_reg;

    // (hi - lo) * offset, never negative since lo <= hi
    assign adj_num_next = 14'(src_word.hi - src_word.lo) * 14'(src_word.offset);

    // / 60 by reciprocal
    assign adj_prod = 29'(s5_adj_num_reg) * 29'(ADJ_MUL);
    assign adj_next = adj_prod[ADJ_SHIFT +: ChanW];

    assign up   = s6_lo_reg + s6_adj_reg;
    assign down = s6_hi_reg - s6_adj_reg;

    always_comb
    begin
        case (s6_sector_reg)
            SEC_RED_GREEN_UP:
            begin
                s7_next = '{red: s6_hi_reg, green: up, blue: s6_lo_reg};
            end
            SEC_GREEN_RED_DOWN:
            begin
                s7_next = '{red: down, green: s6_hi_reg, blue: s6_lo_reg};
            end
            SEC_GREEN_BLUE_UP:
            begin
                s7_next = '{red: s6_lo_reg, green: s6_hi_reg, blue: up};
            end
            SEC_BLUE_GREEN_DOWN:
            begin
                s7_next = '{red: s6_lo_reg, green: down, blue: s6_hi_reg};
            end
            SEC_BLUE_RED_UP:
            begin
                s7_next = '{red: up, green: s6_lo_reg, blue: s6_hi_reg};
            end
            default:
            begin
                s7_next = '{red: s6_hi_reg, green: s6_lo_reg, blue: down};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (s5_ready)
            begin
                s5_valid_reg <= src_valid;
            end
            if (s6_ready)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
            if (s7_ready)
            begin
                s7_valid_reg <= s6_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready && src_valid)
        begin
            s5_adj_num_reg <= adj_num_next;
            s5_sector_reg  <= src_word.sector;
            s5_hi_reg      <= src_word.hi;
            s5_lo_reg      <= src_word.lo;
        end
        if (s6_ready && s5_valid_reg)
        begin
            s6_adj_reg    <= adj_next;
            s6_sector_reg <= s5_sector_reg;
            s6_hi_reg     <= s5_hi_reg;
            s6_lo_reg     <= s5_lo_reg;
        end
        if (s7_ready && s6_valid_reg)
        begin
            s7_word_reg <= s7_next;
        end
    end

endmodule
